[rtl/triangle_strip_grid_index_gen_core_macros.svh]
// Assertion macros for the triangle strip index generator RTL.
// Defining NO_ASSERTIONS compiles every macro use to nothing.
`ifndef TRIANGLE_STRIP_GRID_INDEX_GEN_CORE_MACROS_SVH
`define TRIANGLE_STRIP_GRID_INDEX_GEN_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define TSG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define TSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define TSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/tsg_pkg.sv]
// Package for the triangle strip grid index generator.
// Holds fixed widths, register indexes, the phase encoding and interface structs.
`timescale 1ns / 1ps
package tsg_pkg;

    localparam int VERTEX_W   = 16;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0]  CFG_TILES_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_TILES_Y = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RESET_TILES = 8'd32;

    // Emit phases of the strip sequencer, one-hot.
    typedef enum logic [6:0] {
        PH_FIRST  = 7'b0000001,
        PH_SECOND = 7'b0000010,
        PH_TOP    = 7'b0000100,
        PH_BOTTOM = 7'b0001000,
        PH_JOIN_A = 7'b0010000,
        PH_JOIN_B = 7'b0100000,
        PH_JOIN_C = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic fire;     // one item is processed this cycle
        logic restart;  // the item asks for the strip to start over
        logic clear;    // a register write returns the strip to its start
    } t_seq_ctl;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_index;
        logic                last;
    } t_seq_out;

endpackage

[rtl/tsg_cfg.sv]
// Grid size registers of the triangle strip index generator.
// Depends on tsg_pkg; gives effective tile counts and a strip clear pulse.
`timescale 1ns / 1ps
module tsg_cfg
    import tsg_pkg::*;
#(
    parameter int TILE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [TILE_BITS-1:0]  o_tiles_x,
    output logic [TILE_BITS-1:0]  o_tiles_y,
    output logic                  o_clear
);

    logic [TILE_BITS-1:0] r_tiles_x;
    logic [TILE_BITS-1:0] r_tiles_y;
    logic                 hit_x;
    logic                 hit_y;

    always_comb begin
        hit_x = 1'b0;
        hit_y = 1'b0;
        unique case (i_cfg_index)
            CFG_TILES_X: begin
                hit_x = i_cfg_we;
            end
            CFG_TILES_Y: begin
                hit_y = i_cfg_we;
            end
            default: begin
                hit_x = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_x <= RESET_TILES[TILE_BITS-1:0];
            r_tiles_y <= RESET_TILES[TILE_BITS-1:0];
        end else begin
            if (hit_x) begin
                r_tiles_x <= i_cfg_data[TILE_BITS-1:0];
            end
            if (hit_y) begin
                r_tiles_y <= i_cfg_data[TILE_BITS-1:0];
            end
        end
    end

    // A count of zero behaves as a single tile.
    assign o_tiles_x = (r_tiles_x == '0) ? TILE_BITS'(1) : r_tiles_x;
    assign o_tiles_y = (r_tiles_y == '0) ? TILE_BITS'(1) : r_tiles_y;
    assign o_clear   = hit_x | hit_y;

endmodule

[rtl/tsg_seq.sv]
// Strip sequencer: phase, column, row, direction and row base registers
// with the one-step index logic. Depends on tsg_pkg.
`timescale 1ns / 1ps
module tsg_seq
    import tsg_pkg::*;
#(
    parameter int TILE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [TILE_BITS-1:0] i_tiles_x,
    input  logic [TILE_BITS-1:0] i_tiles_y,
    input  t_seq_ctl             i_ctl,
    output t_seq_out             o_out
);

    t_phase                r_phase, n_phase, w_phase;
    logic [TILE_BITS-1:0]  r_cc, n_cc, w_cc;
    logic [TILE_BITS-1:0]  r_rc, n_rc, w_rc;
    logic                  r_sweep, n_sweep, w_sweep;
    logic [VERTEX_W-1:0]   r_base, n_base, w_base;

    logic                  start;
    logic [TILE_BITS-1:0]  col;
    logic [TILE_BITS-1:0]  cc_inc;
    logic [TILE_BITS:0]    rc_inc;
    logic [VERTEX_W-1:0]   stride;
    logic [VERTEX_W-1:0]   col_w;
    logic [VERTEX_W-1:0]   edge_col;
    logic [VERTEX_W-1:0]   idx;
    logic                  last;

    // An unknown phase code starts the strip over, like a restart.
    always_comb begin
        unique case (r_phase)
            PH_FIRST, PH_SECOND, PH_TOP, PH_BOTTOM,
            PH_JOIN_A, PH_JOIN_B, PH_JOIN_C: begin
                start = i_ctl.restart;
            end
            default: begin
                start = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_phase = start ? PH_FIRST : r_phase;
        w_cc    = start ? '0 : r_cc;
        w_rc    = start ? '0 : r_rc;
        w_sweep = start ? 1'b1 : r_sweep;
        w_base  = start ? '0 : r_base;

        col      = w_sweep ? TILE_BITS'(w_cc + 1'b1) : TILE_BITS'(i_tiles_x - w_cc - 1'b1);
        cc_inc   = TILE_BITS'(w_cc + 1'b1);
        rc_inc   = {1'b0, w_rc} + 1'b1;
        stride   = VERTEX_W'(i_tiles_x) + 1'b1;
        col_w    = VERTEX_W'(col);
        edge_col = w_sweep ? VERTEX_W'(i_tiles_x) : '0;

        n_phase = w_phase;
        n_cc    = w_cc;
        n_rc    = w_rc;
        n_sweep = w_sweep;
        n_base  = w_base;
        idx     = '0;
        last    = 1'b0;

        unique case (w_phase)
            PH_FIRST: begin
                n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                idx     = stride;
                n_cc    = '0;
                n_phase = PH_TOP;
            end
            PH_TOP: begin
                idx     = w_base + col_w;
                n_phase = PH_BOTTOM;
            end
            PH_BOTTOM: begin
                idx  = w_base + stride + col_w;
                n_cc = cc_inc;
                if (cc_inc >= i_tiles_x) begin
                    if (rc_inc >= {1'b0, i_tiles_y}) begin
                        // Final index: the strip returns to its start.
                        last    = 1'b1;
                        n_phase = PH_FIRST;
                        n_cc    = '0;
                        n_rc    = '0;
                        n_sweep = 1'b1;
                        n_base  = '0;
                    end else begin
                        n_phase = PH_JOIN_A;
                    end
                end else begin
                    n_phase = PH_TOP;
                end
            end
            PH_JOIN_A: begin
                idx     = w_base + stride + edge_col;
                n_phase = PH_JOIN_B;
            end
            PH_JOIN_B: begin
                idx     = w_base + stride + edge_col;
                n_phase = PH_JOIN_C;
            end
            PH_JOIN_C: begin
                idx     = w_base + {stride[VERTEX_W-2:0], 1'b0} + edge_col;
                n_rc    = TILE_BITS'(w_rc + 1'b1);
                n_base  = w_base + stride;
                n_sweep = ~w_sweep;
                n_cc    = '0;
                n_phase = PH_TOP;
            end
            default: begin
                n_phase = PH_SECOND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_phase <= PH_FIRST;
            r_cc    <= '0;
            r_rc    <= '0;
            r_sweep <= 1'b1;
            r_base  <= '0;
        end else if (i_ctl.fire) begin
            r_phase <= n_phase;
            r_cc    <= n_cc;
            r_rc    <= n_rc;
            r_sweep <= n_sweep;
            r_base  <= n_base;
        end
    end

    assign o_out.vertex_index = idx;
    assign o_out.last         = last;

endmodule

[rtl/triangle_strip_grid_index_gen_core.sv]
// Top level of the triangle strip grid index generator.
// Depends on tsg_pkg, tsg_cfg, tsg_seq and the assertion macro header.
`timescale 1ns / 1ps
`include "triangle_strip_grid_index_gen_core_macros.svh"

// Each accepted item yields one vertex index of a serpentine triangle strip
// over a tiles_x by tiles_y grid, where vertex (column c, row r) has index
// r*(tiles_x+1)+c. The strip opens with vertices 0 and tiles_x+1, sweeps the
// rows in alternating direction and puts three join indices between rows, for
// 2*tiles_x*tiles_y+3*tiles_y-1 indices in all; the final one carries
// o_last_of_strip and the item after it starts a new strip. Setting i_restart
// on an item starts the strip over at once. The block sustains one item per
// clock while the output is not stalled: an item is captured in an input
// register, the next index is formed from it by one add path of the
// sequencer, and the result sits in an output register that drives o_valid.
// The input side stalls only when both registers are full and the output is
// stalled. A write to either grid size register returns the sequencer to the
// start of the strip; write them only while no item is in flight. A tile count
// of zero acts as one, and only the low TILE_BITS bits of a count are kept.
module triangle_strip_grid_index_gen_core
    import tsg_pkg::*;
#(
    parameter int TILE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VERTEX_W-1:0]   o_vertex_index,
    output logic                  o_last_of_strip
);

    logic [TILE_BITS-1:0] tiles_x;
    logic [TILE_BITS-1:0] tiles_y;
    logic                 cfg_clear;

    // Input register stage.
    logic                 r_s1_valid;
    logic                 r_s1_restart;

    // Output register stage.
    logic                 r_out_valid;
    logic [VERTEX_W-1:0]  r_out_index;
    logic                 r_out_last;

    logic                 out_free;
    logic                 s1_fire;
    logic                 in_accept;
    t_seq_ctl             seq_ctl;
    t_seq_out             seq_out;

    // The output register can take a new result when it is empty or being
    // drained this cycle; the input register moves whenever that holds.
    assign out_free  = !r_out_valid || !i_stall;
    assign s1_fire   = r_s1_valid && out_free;
    assign o_stall   = r_s1_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    tsg_cfg #(
        .TILE_BITS (TILE_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tiles_x   (tiles_x),
        .o_tiles_y   (tiles_y),
        .o_clear     (cfg_clear)
    );

    assign seq_ctl.fire    = s1_fire;
    assign seq_ctl.restart = r_s1_restart;
    assign seq_ctl.clear   = cfg_clear;

    tsg_seq #(
        .TILE_BITS (TILE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tiles_x (tiles_x),
        .i_tiles_y (tiles_y),
        .i_ctl     (seq_ctl),
        .o_out     (seq_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_index <= seq_out.vertex_index;
            r_out_last  <= seq_out.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_vertex_index  = r_out_index;
    assign o_last_of_strip = r_out_last;

    // The input side only stalls with both stages full and the output held.
    `TSG_ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_s1_valid && r_out_valid && i_stall, "input stalled while a stage had room")

    // A processed item always lands in the output register.
    `TSG_ASSERT_NEXT(a_fire_loads_output, i_clk, i_rst_n, s1_fire, r_out_valid, "processed item did not reach the output register")

    // A restart item always yields vertex 0, never flagged as last.
    `TSG_ASSERT_NEXT(a_restart_gives_first, i_clk, i_rst_n, s1_fire && r_s1_restart, (r_out_index == '0) && !r_out_last, "restart did not produce the first strip index")

endmodule

[tb/sv/tb_triangle_strip_grid_index_gen_core.sv]
// Self-checking testbench for triangle_strip_grid_index_gen_core.
// Depends on tsg_pkg and the core RTL. A built-in strip predictor checks every
// index under random input gaps, output stalls and grid size changes.
`timescale 1ns / 1ps

module tb_triangle_strip_grid_index_gen_core;
    import tsg_pkg::*;

    localparam int TILE_BITS = 8;
    localparam int unsigned TILE_MASK = (1 << TILE_BITS) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 180;

    // Register indexes past the two grid sizes; writes there must do nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // One index of the strip together with its end flag.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } t_strip_vertex;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_TILES_X;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_restart = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [VERTEX_W-1:0]   o_vertex_index;
    logic                  o_last_of_strip;

    triangle_strip_grid_index_gen_core #(
        .TILE_BITS(TILE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_vertex_index (o_vertex_index),
        .o_last_of_strip(o_last_of_strip)
    );

    // The clock runs with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Restart flags of the items still waiting to be driven.
    logic          restart_q[$];
    // Indices the block owes us, oldest first.
    t_strip_vertex expected_vertices[$];

    // Shadow copy of the grid registers and of the strip sequencer.
    logic [7:0]    grid_tx;
    logic [7:0]    grid_ty;
    logic [7:0]    col_cnt;
    logic [7:0]    row_cnt;
    logic          rightward;
    t_phase        phase;
    logic [15:0]   row_base;

    // Set by the monitor at the rising edge when an item was taken.
    bit            item_taken = 1'b0;
    // When set, neither side inserts gaps or stalls.
    bit            no_gaps = 1'b0;

    int            queued_count = 0;
    int            checked_count = 0;
    int            error_count = 0;
    int            strips_done = 0;
    int            restart_count = 0;
    int            cfg_writes = 0;
    int            cycle_count = 0;

    // A register holding zero counts as one tile; only TILE_BITS bits are kept.
    function automatic int unsigned eff_tiles(logic [7:0] v);
        int unsigned m;
        m = v & TILE_MASK;
        return (m == 0) ? 1 : m;
    endfunction

    function automatic int strip_len(logic [7:0] tx, logic [7:0] ty);
        return 2 * eff_tiles(tx) * eff_tiles(ty) + 3 * eff_tiles(ty) - 1;
    endfunction

    function automatic void strip_home();
        col_cnt   = '0;
        row_cnt   = '0;
        rightward = 1'b1;
        phase     = PH_FIRST;
        row_base  = '0;
    endfunction

    // Steps the shadow sequencer by one item and returns the index it emits.
    task automatic advance_strip(input logic restart, output t_strip_vertex res);
        int unsigned tx;
        int unsigned ty;
        int unsigned stride;
        int unsigned col;
        int unsigned idx;
        tx = eff_tiles(grid_tx);
        ty = eff_tiles(grid_ty);
        stride = tx + 1;
        idx = 0;
        res.last = 1'b0;
        if (restart) begin
            strip_home();
        end
        // Column of the next edge, counted from the left; col_cnt counts from the side the sweep started on.
        col = rightward ? col_cnt + 1 : tx - col_cnt - 1;
        case (phase)
            PH_FIRST: begin
                idx = 0;
                phase = PH_SECOND;
            end
            PH_SECOND: begin
                idx = stride;
                col_cnt = '0;
                phase = PH_TOP;
            end
            PH_TOP: begin
                idx = row_base + col;
                phase = PH_BOTTOM;
            end
            PH_BOTTOM: begin
                idx = row_base + stride + col;
                col_cnt = col_cnt + 8'd1;
                if (col_cnt >= tx) begin
                    if (row_cnt + 1 >= ty) begin
                        res.last = 1'b1;
                        strip_home();
                    end else begin
                        phase = PH_JOIN_A;
                    end
                end else begin
                    phase = PH_TOP;
                end
            end
            PH_JOIN_A, PH_JOIN_B: begin
                // The corner vertex at the end of the row, twice.
                idx = row_base + stride + (rightward ? tx : 0);
                phase = (phase == PH_JOIN_A) ? PH_JOIN_B : PH_JOIN_C;
            end
            default: begin
                // The vertex below the corner opens the next row.
                idx = row_base + 2 * stride + (rightward ? tx : 0);
                row_cnt = row_cnt + 8'd1;
                row_base = row_base + stride[15:0];
                rightward = ~rightward;
                col_cnt = '0;
                phase = PH_TOP;
            end
        endcase
        res.vertex = idx[15:0];
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Driver: presents items from the queue and drives the output stall.
    // Both change only at the falling edge.
    always @(negedge i_clk) begin : driver
        int send_gap;
        int recv_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
            send_gap = 0;
            recv_stall = 0;
        end else begin
            // A presented item is held until it has been taken.
            if (!i_valid || item_taken) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if (restart_q.size() > 0) begin
                    i_valid   <= 1'b1;
                    i_restart <= restart_q.pop_front();
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (recv_stall > 0) begin
                i_stall <= 1'b1;
                recv_stall--;
            end else begin
                i_stall <= 1'b0;
                recv_stall = pick_gap();
            end
        end
    end

    // Monitor: follows register writes and taken items in the shadow
    // sequencer, and checks every result the block hands over.
    always @(posedge i_clk) begin : monitor
        t_strip_vertex want;
        t_strip_vertex got;
        if (!i_rst_n) begin
            grid_tx = RESET_TILES;
            grid_ty = RESET_TILES;
            strip_home();
            item_taken = 1'b0;
        end else begin
            item_taken = i_valid && !o_stall;
            if (i_cfg_we) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_TILES_X: begin
                        grid_tx = i_cfg_data;
                        strip_home();
                    end
                    CFG_TILES_Y: begin
                        grid_ty = i_cfg_data;
                        strip_home();
                    end
                    default: ;
                endcase
            end
            if (item_taken) begin
                advance_strip(i_restart, want);
                expected_vertices.push_back(want);
                if (i_restart) begin
                    restart_count++;
                end
            end
            if (o_valid && !i_stall) begin
                got.vertex = o_vertex_index;
                got.last   = o_last_of_strip;
                if (expected_vertices.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got index %0d last %0b",
                             $time, got.vertex, got.last);
                end else begin
                    want = expected_vertices.pop_front();
                    if (got.vertex !== want.vertex) begin
                        error_count++;
                        $display("%0t: vertex_index mismatch, expected %0d, got %0d",
                                 $time, want.vertex, got.vertex);
                    end
                    if (got.last !== want.last) begin
                        error_count++;
                        $display("%0t: last_of_strip mismatch, expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
                checked_count++;
                if (got.last === 1'b1) begin
                    strips_done++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     queued_count - checked_count);
            $display("FAIL triangle_strip_grid_index_gen_core");
            $finish;
        end
    end

    // Adds n items; each asks for a restart with the given percent chance.
    task automatic queue_items(input int n, input int restart_pct);
        @(posedge i_clk);
        for (int k = 0; k < n; k++) begin
            restart_q.push_back($urandom_range(0, 99) < restart_pct);
        end
        queued_count += n;
    endtask

    // Waits until every item has been taken and its result checked.
    task automatic wait_idle();
        while (checked_count != queued_count) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int rand_items;
        int n;
        int pct;
        int r;
        logic [7:0] tx;
        logic [7:0] ty;
        rand_items = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First the reset grid of 32 by 32, with a restart on
        // the very first item and another one a few indices in.
        queue_items(1, 100);
        queue_items(5, 0);
        queue_items(1, 100);
        queue_items(2, 0);
        wait_idle();

        // Zero tile counts act as one tile: a strip of four indices, run past
        // its end so the next strip starts by itself.
        write_reg(CFG_TILES_X, 8'h00);
        write_reg(CFG_TILES_Y, 8'h00);
        queue_items(6, 0);
        wait_idle();

        // Two rows of one tile exercise the join indices. Writes to the unused
        // register indexes in the middle of the strip must not disturb it.
        write_reg(CFG_TILES_X, 8'd1);
        write_reg(CFG_TILES_Y, 8'd2);
        queue_items(4, 0);
        wait_idle();
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h5A);
        queue_items(6, 0);
        wait_idle();

        // Largest width with one row, and one column with many rows, both
        // run to the end of the strip and one item beyond.
        write_reg(CFG_TILES_Y, 8'd1);
        write_reg(CFG_TILES_X, 8'd255);
        queue_items(strip_len(8'd255, 8'd1) + 1, 0);
        wait_idle();
        write_reg(CFG_TILES_X, 8'd1);
        write_reg(CFG_TILES_Y, 8'd20);
        queue_items(strip_len(8'd1, 8'd20) + 1, 0);
        wait_idle();

        // The largest grid is too long to finish; cover the start of its first
        // row and cut it short with a restart.
        write_reg(CFG_TILES_X, 8'd255);
        write_reg(CFG_TILES_Y, 8'd255);
        no_gaps = 1'b1;
        queue_items(40, 0);
        queue_items(1, 100);
        queue_items(4, 0);
        wait_idle();
        no_gaps = 1'b0;

        // Random part: small grids mostly, each phase either keeps the running
        // strip or changes one or both sizes first.
        while (rand_items < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            tx = (r < 10) ? 8'd0 : (r < 80) ? 8'($urandom_range(1, 6)) :
                 (r < 95) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(41, 255));
            r = $urandom_range(0, 99);
            ty = (r < 10) ? 8'd0 : (r < 85) ? 8'($urandom_range(1, 5)) :
                 8'($urandom_range(6, 255));
            case ($urandom_range(0, 4))
                0: ;
                1: write_reg(CFG_TILES_X, tx);
                2: write_reg(CFG_TILES_Y, ty);
                3: begin
                    write_reg(CFG_TILES_X, tx);
                    write_reg(CFG_TILES_Y, ty);
                end
                default: write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                   8'($urandom));
            endcase
            n = 2 * strip_len(grid_tx, grid_ty) + 2;
            n = $urandom_range(1, (n < 120) ? n : 120);
            n = (n < RANDOM_ITEMS - rand_items) ? n : RANDOM_ITEMS - rand_items;
            r = $urandom_range(0, 99);
            pct = (r < 60) ? 0 : (r < 85) ? 3 : 25;
            queue_items(n, pct);
            rand_items += n;
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d items, %0d complete strips, %0d restarts and %0d register",
                 checked_count, strips_done, restart_count, cfg_writes);
        $display("writes, on grids from 1x1 up to 255x255 tiles, with %0d errors.", error_count);
        if (error_count == 0 && expected_vertices.size() == 0) begin
            $display("PASS triangle_strip_grid_index_gen_core");
        end else begin
            $display("FAIL triangle_strip_grid_index_gen_core");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tsg_pkg.sv
rtl/tsg_cfg.sv
rtl/tsg_seq.sv
rtl/triangle_strip_grid_index_gen_core.sv
tb/sv/tb_triangle_strip_grid_index_gen_core.sv
